>>> hdl/round_robin_quantum_scheduler_top_macros.svh
// Assertion macros for the checker file.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_MACROS_SVH

// Property checked at every clock edge, reset included.
`define RRQS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while out of reset.
`define RRQS_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> hdl/rrqs_pkg.sv
`default_nettype none

package rrqs_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int PTR_W      = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);

    localparam int ID_W       = 8;
    localparam int TIME_W     = 16;
    localparam int NOW_W      = 32;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(4);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int IN_FIELDS_W  = ID_W + 2 * TIME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ID_W + NOW_W + TIME_W + 3;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_SUBMIT = 1'b0,
        CMD_STEP   = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } t_cmd_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } t_pend_entry;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remaining;
    } t_ready_entry;

    typedef struct packed {
        logic [ID_W-1:0]   run_id;
        logic [NOW_W-1:0]  slice_start;
        logic [TIME_W-1:0] slice_length;
        logic              task_done;
        logic              idle;
        logic              rejected;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SLICE,
        ST_ADMIT,
        ST_WAIT
    } t_state;

    // Circular pointer step over the task stores.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_TASKS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rrqs_ram.sv
`default_nettype none

module rrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/rrqs_front.sv
`default_nettype none

module rrqs_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_valid,
    output logic                                o_s_ready,
    input  wire logic [rrqs_pkg::IN_TDATA_W-1:0] i_s_data,
    input  wire logic [0:0]                     i_s_user,
    output logic                                o_cmd_valid,
    output rrqs_pkg::t_cmd_item                 o_cmd,
    input  wire logic                           i_cmd_pop
);

    rrqs_pkg::t_cmd_item                r_q [rrqs_pkg::CMDQ_DEPTH];
    logic [rrqs_pkg::CMDQ_PW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [rrqs_pkg::CMDQ_PW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [rrqs_pkg::CMDQ_CW-1:0]       r_count, n_count;
    rrqs_pkg::t_cmd_item                cmd_in;
    logic                               push, pop;

    // Classify the beat and unpack its fields.
    always_comb begin
        cmd_in.id      = i_s_data[rrqs_pkg::ID_W-1:0];
        cmd_in.arrival = i_s_data[rrqs_pkg::ID_W +: rrqs_pkg::TIME_W];
        cmd_in.burst   = i_s_data[rrqs_pkg::ID_W + rrqs_pkg::TIME_W +: rrqs_pkg::TIME_W];
        unique case (i_s_user[0])
            1'b0: cmd_in.kind = rrqs_pkg::CMD_SUBMIT;
            1'b1: cmd_in.kind = rrqs_pkg::CMD_STEP;
        endcase
    end

    assign o_s_ready   = (r_count != rrqs_pkg::CMDQ_CW'(rrqs_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_s_valid && o_s_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == rrqs_pkg::CMDQ_PW'(rrqs_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == rrqs_pkg::CMDQ_PW'(rrqs_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rrqs_back.sv
`default_nettype none

module rrqs_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire rrqs_pkg::t_cmd_item          i_cmd,
    output logic                              o_cmd_pop,
    input  wire logic [rrqs_pkg::TIME_W-1:0]  i_quantum,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output rrqs_pkg::t_result                 o_res
);

    localparam int PW = rrqs_pkg::PTR_W;
    localparam int CW = rrqs_pkg::CNT_W;
    localparam int NW = rrqs_pkg::NOW_W;
    localparam int TW = rrqs_pkg::TIME_W;

    rrqs_pkg::t_state       r_state, n_state;
    logic [PW-1:0]          r_pend_head, n_pend_head, r_pend_tail, n_pend_tail;
    logic [CW-1:0]          r_pend_cnt, n_pend_cnt;
    logic [PW-1:0]          r_ready_head, n_ready_head, r_ready_tail, n_ready_tail;
    logic [CW-1:0]          r_ready_cnt, n_ready_cnt;
    logic [NW-1:0]          r_now, n_now;
    logic                   r_res_valid, n_res_valid;
    rrqs_pkg::t_result      r_res, n_res;
    rrqs_pkg::t_ready_entry r_head, n_head;
    logic [TW-1:0]          r_slice, n_slice;
    logic [NW-1:0]          r_end, n_end;

    logic                   pend_we, ready_we;
    rrqs_pkg::t_pend_entry  pend_wdata, pend_rdata;
    rrqs_pkg::t_ready_entry ready_wdata, ready_rdata;

    logic                   out_free, pend_full, ready_full, arr_ok;
    logic [TW-1:0]          slice_c, rem_left;
    logic [NW:0]            sum_c;
    logic [NW-1:0]          arr_ext;

    rrqs_ram #(
        .WIDTH ($bits(rrqs_pkg::t_pend_entry)),
        .DEPTH (rrqs_pkg::MAX_TASKS)
    ) u_pend_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pend_we),
        .i_wr_addr (r_pend_tail),
        .i_wr_data (pend_wdata),
        .i_rd_addr (r_pend_head),
        .o_rd_data (pend_rdata)
    );

    rrqs_ram #(
        .WIDTH ($bits(rrqs_pkg::t_ready_entry)),
        .DEPTH (rrqs_pkg::MAX_TASKS)
    ) u_ready_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ready_we),
        .i_wr_addr (r_ready_tail),
        .i_wr_data (ready_wdata),
        .i_rd_addr (r_ready_head),
        .o_rd_data (ready_rdata)
    );

    assign out_free   = !r_res_valid || i_res_ready;
    assign pend_full  = (r_pend_cnt == CW'(rrqs_pkg::MAX_TASKS));
    assign ready_full = (r_ready_cnt == CW'(rrqs_pkg::MAX_TASKS));
    assign arr_ext    = {{(NW - TW){1'b0}}, pend_rdata.arrival};
    assign arr_ok     = (arr_ext <= r_end);
    assign slice_c    = (r_head.remaining < i_quantum) ? r_head.remaining : i_quantum;
    assign sum_c      = {1'b0, r_now} + {{(NW + 1 - TW){1'b0}}, slice_c};
    assign rem_left   = r_head.remaining - r_slice;
    assign pend_wdata = '{id: i_cmd.id, arrival: i_cmd.arrival, burst: i_cmd.burst};

    always_comb begin
        n_state      = r_state;
        n_pend_head  = r_pend_head;
        n_pend_tail  = r_pend_tail;
        n_pend_cnt   = r_pend_cnt;
        n_ready_head = r_ready_head;
        n_ready_tail = r_ready_tail;
        n_ready_cnt  = r_ready_cnt;
        n_now        = r_now;
        n_res_valid  = r_res_valid && !i_res_ready;
        n_res        = r_res;
        n_head       = r_head;
        n_slice      = r_slice;
        n_end        = r_end;
        o_cmd_pop    = 1'b0;
        pend_we      = 1'b0;
        ready_we     = 1'b0;
        ready_wdata  = '{id: pend_rdata.id, remaining: pend_rdata.burst};

        unique case (r_state)
            rrqs_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == rrqs_pkg::CMD_SUBMIT) begin
                        if (out_free) begin
                            o_cmd_pop   = 1'b1;
                            n_res_valid = 1'b1;
                            n_res       = '0;
                            n_res.rejected = pend_full;
                            if (!pend_full) begin
                                pend_we     = 1'b1;
                                n_pend_tail = rrqs_pkg::ptr_inc(r_pend_tail);
                                n_pend_cnt  = r_pend_cnt + 1'b1;
                            end
                        end
                    end else if (r_ready_cnt == '0 && r_pend_cnt == '0) begin
                        if (out_free) begin
                            o_cmd_pop   = 1'b1;
                            n_res_valid = 1'b1;
                            n_res       = '0;
                            n_res.idle  = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_state   = rrqs_pkg::ST_FETCH;
                    end
                end
            end

            rrqs_pkg::ST_FETCH: begin
                if (r_ready_cnt == '0) begin
                    // Nothing ready: admit the oldest pending task; time jumps forward to its arrival if that is later.
                    n_head = '{id: pend_rdata.id, remaining: pend_rdata.burst};
                    if (arr_ext > r_now) begin
                        n_now = arr_ext;
                    end
                    n_pend_head  = rrqs_pkg::ptr_inc(r_pend_head);
                    n_pend_cnt   = r_pend_cnt - 1'b1;
                    ready_we     = 1'b1;
                    n_ready_tail = rrqs_pkg::ptr_inc(r_ready_tail);
                    n_ready_cnt  = CW'(1);
                end else begin
                    n_head = ready_rdata;
                end
                n_state = rrqs_pkg::ST_SLICE;
            end

            rrqs_pkg::ST_SLICE: begin
                n_slice = slice_c;
                n_end   = sum_c[NW] ? '1 : sum_c[NW-1:0];
                n_state = rrqs_pkg::ST_ADMIT;
            end

            rrqs_pkg::ST_ADMIT: begin
                if (r_pend_cnt != '0 && !ready_full && arr_ok) begin
                    ready_we     = 1'b1;
                    n_ready_tail = rrqs_pkg::ptr_inc(r_ready_tail);
                    n_ready_cnt  = r_ready_cnt + 1'b1;
                    n_pend_head  = rrqs_pkg::ptr_inc(r_pend_head);
                    n_pend_cnt   = r_pend_cnt - 1'b1;
                    n_state      = rrqs_pkg::ST_WAIT;
                end else if (out_free) begin
                    // Retire the head; requeue it at the tail if work remains.
                    n_now        = r_end;
                    n_ready_head = rrqs_pkg::ptr_inc(r_ready_head);
                    if (rem_left != '0) begin
                        ready_we     = 1'b1;
                        ready_wdata  = '{id: r_head.id, remaining: rem_left};
                        n_ready_tail = rrqs_pkg::ptr_inc(r_ready_tail);
                    end else begin
                        n_ready_cnt = r_ready_cnt - 1'b1;
                    end
                    n_res_valid = 1'b1;
                    n_res       = '{run_id:       r_head.id,
                                    slice_start:  r_now,
                                    slice_length: r_slice,
                                    task_done:    (rem_left == '0),
                                    idle:         1'b0,
                                    rejected:     1'b0};
                    n_state     = rrqs_pkg::ST_IDLE;
                end
            end

            // Wait state so the pending read catches up with the new head.
            rrqs_pkg::ST_WAIT: begin
                n_state = rrqs_pkg::ST_ADMIT;
            end

            default: begin
                n_state = rrqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rrqs_pkg::ST_IDLE;
            r_pend_head  <= '0;
            r_pend_tail  <= '0;
            r_pend_cnt   <= '0;
            r_ready_head <= '0;
            r_ready_tail <= '0;
            r_ready_cnt  <= '0;
            r_now        <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_head  <= n_pend_head;
            r_pend_tail  <= n_pend_tail;
            r_pend_cnt   <= n_pend_cnt;
            r_ready_head <= n_ready_head;
            r_ready_tail <= n_ready_tail;
            r_ready_cnt  <= n_ready_cnt;
            r_now        <= n_now;
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_head  <= n_head;
        r_slice <= n_slice;
        r_end   <= n_end;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

>>> hdl/round_robin_quantum_scheduler_top.sv
// A submit or an idle step gives its result beat from the command queue through the
// registered result; a running step passes the fetch, slice and admit states, plus a
// wait and admit pass per task admitted by arrival time. Submits sustain 1 beat per
// cycle unless the output stalls; a step holds the scheduler engine until it is done.
// Reset (synchronous, active low) empties both task stores and the command queue,
// zeroes the time and sets the quantum to 4; store contents are not cleared.
`default_nettype none

module round_robin_quantum_scheduler_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [rrqs_pkg::TIME_W-1:0]     i_cfg_wr_data,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // task_id[7:0], arrival_time[23:8], burst_length[39:24]
    input  wire logic [rrqs_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]                      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // run_id[7:0], slice_start[39:8], slice_length[55:40], task_done[56],
    // idle[57], rejected[58], zero fill above
    output logic [rrqs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    logic [rrqs_pkg::TIME_W-1:0] r_quantum;
    logic [rrqs_pkg::TIME_W-1:0] quantum_eff;
    logic                        cmd_valid, cmd_pop;
    rrqs_pkg::t_cmd_item         cmd;
    rrqs_pkg::t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrqs_pkg::QUANTUM_RESET;
        end else if (i_cfg_wr_en) begin
            r_quantum <= i_cfg_wr_data;
        end
    end

    // A zero quantum runs as one.
    assign quantum_eff = (r_quantum == '0) ? rrqs_pkg::TIME_W'(1) : r_quantum;

    rrqs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    rrqs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_quantum   (quantum_eff),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {{(rrqs_pkg::OUT_TDATA_W - rrqs_pkg::OUT_FIELDS_W){1'b0}},
                             res.rejected, res.idle, res.task_done,
                             res.slice_length, res.slice_start, res.run_id};

endmodule

`default_nettype wire

>>> hdl/rrqs_chk.sv
`default_nettype none

`include "round_robin_quantum_scheduler_top_macros.svh"

module rrqs_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tready,
    input wire logic                             i_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [rrqs_pkg::OUT_TDATA_W-1:0] i_m_tdata
);

    // Reset empties the command queue and drops any waiting result.
    `RRQS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> i_s_tready && !i_m_tvalid, "reset did not clear both sides")

    // No result beat may appear too soon after reset.
    `RRQS_ASSERT_ALWAYS(a_reset_latency, i_clk, !i_rst_n |=> ##1 !i_m_tvalid, "result beat too soon after reset")

    // Hold a stalled result beat.
    `RRQS_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "stalled result beat changed")

endmodule

bind round_robin_quantum_scheduler_top rrqs_chk u_rrqs_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire
